// ===== rtl/epc_pkg.sv =====
// Shared types, codes and constants of the event-select performance counter unit.
package epc_pkg;

  // Bus and field widths
  localparam int DATA_W       = 32;
  localparam int FUNC_W       = 2;
  localparam int REG_W        = 5;
  localparam int SEL_W        = 5;
  localparam int LANE_BITS    = 8;
  localparam int LANES        = 4;
  localparam int MAX_COUNTERS = 8;
  localparam int CNT_IDX_W    = 3;

  // Defaults of the top-level parameters
  localparam int NUM_COUNTERS_DEF = 8;
  localparam int COUNT_WIDTH_DEF  = 64;

  // Control register bits
  localparam int CTRL_CLEAR_BIT = 13;
  localparam int CTRL_RUN_BIT   = 15;

  // Function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Register numbers
  localparam logic [REG_W-1:0] REG_CTRL   = 5'd0;
  localparam logic [REG_W-1:0] REG_SEL_LO = 5'd1;
  localparam logic [REG_W-1:0] REG_SEL_HI = 5'd2;

  // All selectors, lane n of the packed vector is counter n
  typedef logic [MAX_COUNTERS-1:0][SEL_W-1:0] sel_vec_t;

  // Decoded command handed from the decoder to the datapath
  typedef struct packed {
    logic                 tick;
    logic                 wr_ctrl;
    logic                 wr_sel_lo;
    logic                 wr_sel_hi;
    logic                 clear;
    logic                 rd_ctrl;
    logic                 rd_sel_lo;
    logic                 rd_sel_hi;
    logic                 rd_cnt;
    logic                 cnt_hi;
    logic [CNT_IDX_W-1:0] cnt_idx;
    logic                 known;
  } cmd_t;

endpackage

// ===== rtl/epc_if.sv =====
// Valid/ready channel interfaces for request and response words.
interface epc_req_if;
  logic                         valid;
  logic                         ready;
  logic [epc_pkg::FUNC_W-1:0]   func;
  logic [epc_pkg::REG_W-1:0]    reg_index;
  logic [epc_pkg::DATA_W-1:0]   write_data;
  logic [epc_pkg::DATA_W-1:0]   event_bits;

  modport source (output valid, func, reg_index, write_data, event_bits, input ready);
  modport sink   (input valid, func, reg_index, write_data, event_bits, output ready);
endinterface

interface epc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [epc_pkg::DATA_W-1:0]   read_data;
  logic                         known_register;

  modport source (output valid, read_data, known_register, input ready);
  modport sink   (input valid, read_data, known_register, output ready);
endinterface

// ===== rtl/event_select_performance_counters_top.sv =====
// Event-select performance counter unit: decode, register file, counters, result register.
// A result word appears in the cycle after its request word is accepted.
// Throughput: one request word per cycle; the result register frees itself when taken,
// so ready drops only while a result waits and the response side stalls.
// Reset (synchronous, active high): stops counting, clears all selectors and counters,
// and empties the result register.
module event_select_performance_counters_top #(
  parameter int NUM_COUNTERS = epc_pkg::NUM_COUNTERS_DEF,
  parameter int COUNT_WIDTH  = epc_pkg::COUNT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  epc_req_if.sink   req,
  epc_rsp_if.source rsp
);

  epc_pkg::cmd_t                  cmd;
  logic                           accept;
  logic                           run;
  epc_pkg::sel_vec_t              sel;
  logic [2*epc_pkg::DATA_W-1:0]   cnt_value;
  logic [epc_pkg::DATA_W-1:0]     sel_word;
  logic [epc_pkg::DATA_W-1:0]     rdata_next;
  logic                           rsp_valid;
  logic [epc_pkg::DATA_W-1:0]     read_data;
  logic                           known_register;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  epc_decode #(
    .NUM_COUNTERS (NUM_COUNTERS)
  ) u_decode (
    .func       (req.func),
    .reg_index  (req.reg_index),
    .write_data (req.write_data),
    .cmd        (cmd)
  );

  epc_counters #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_counters (
    .clk        (clk),
    .rst        (rst),
    .count_en   (accept && cmd.tick && run),
    .clear      (accept && cmd.clear),
    .sel        (sel),
    .event_bits (req.event_bits),
    .rd_idx     (cmd.cnt_idx),
    .rd_value   (cnt_value)
  );

  // Update run enable and the selectors present in this configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      sel <= '0;
    end else if (accept) begin
      if (cmd.wr_ctrl) begin
        run <= req.write_data[epc_pkg::CTRL_RUN_BIT];
      end
      for (int n = 0; n < NUM_COUNTERS; n++) begin
        if ((n < epc_pkg::LANES) ? cmd.wr_sel_lo : cmd.wr_sel_hi) begin
          sel[n] <= req.write_data[(n % epc_pkg::LANES)*epc_pkg::LANE_BITS +: epc_pkg::SEL_W];
        end
      end
    end
  end

  // Gather the addressed selector word; absent lanes stay zero
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < epc_pkg::LANES; i++) begin
      sel_word[i*epc_pkg::LANE_BITS +: epc_pkg::SEL_W] =
        cmd.rd_sel_hi ? sel[i + epc_pkg::LANES] : sel[i];
    end
  end

  // Read mux; ticks, writes and unknown registers give zero
  always_comb begin
    rdata_next = '0;
    if (cmd.rd_ctrl) begin
      rdata_next[epc_pkg::CTRL_RUN_BIT] = run;
    end else if (cmd.rd_sel_lo || cmd.rd_sel_hi) begin
      rdata_next = sel_word;
    end else if (cmd.rd_cnt) begin
      rdata_next = cmd.cnt_hi ? cnt_value[2*epc_pkg::DATA_W-1:epc_pkg::DATA_W]
                              : cnt_value[epc_pkg::DATA_W-1:0];
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= rdata_next;
      known_register <= cmd.known;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.read_data      = read_data;
  assign rsp.known_register = known_register;

endmodule

// ===== rtl/epc_decode.sv =====
// Request decoder: turns function code and register number into a command.
module epc_decode #(
  parameter int NUM_COUNTERS = epc_pkg::NUM_COUNTERS_DEF
) (
  input  logic [epc_pkg::FUNC_W-1:0] func,
  input  logic [epc_pkg::REG_W-1:0]  reg_index,
  input  logic [epc_pkg::DATA_W-1:0] write_data,
  output epc_pkg::cmd_t              cmd
);

  logic is_wr;
  logic is_rd;
  logic hit_ctrl;
  logic hit_sel_lo;
  logic hit_sel_hi;
  logic hit_cnt;

  // Classify the function code
  always_comb begin
    is_wr = 1'b0;
    is_rd = 1'b0;
    unique case (func)
      epc_pkg::FUNC_TICK:  ;
      epc_pkg::FUNC_WRITE: is_wr = 1'b1;
      epc_pkg::FUNC_READ:  is_rd = 1'b1;
      default: ;
    endcase
  end

  assign cmd.tick = (func == epc_pkg::FUNC_TICK);

  // Decode the register number; counters sit at 16 and up, two words each
  assign hit_ctrl   = (reg_index == epc_pkg::REG_CTRL);
  assign hit_sel_lo = (reg_index == epc_pkg::REG_SEL_LO);
  assign hit_sel_hi = (reg_index == epc_pkg::REG_SEL_HI);
  assign hit_cnt    = reg_index[4] && ({1'b0, reg_index[3:1]} < 4'(NUM_COUNTERS));

  assign cmd.wr_ctrl   = is_wr && hit_ctrl;
  assign cmd.wr_sel_lo = is_wr && hit_sel_lo;
  assign cmd.wr_sel_hi = is_wr && hit_sel_hi;
  assign cmd.clear     = is_wr && hit_ctrl && write_data[epc_pkg::CTRL_CLEAR_BIT];
  assign cmd.rd_ctrl   = is_rd && hit_ctrl;
  assign cmd.rd_sel_lo = is_rd && hit_sel_lo;
  assign cmd.rd_sel_hi = is_rd && hit_sel_hi;
  assign cmd.rd_cnt    = is_rd && hit_cnt;
  assign cmd.cnt_hi    = reg_index[0];
  assign cmd.cnt_idx   = reg_index[3:1];
  assign cmd.known     = (is_wr || is_rd) && (hit_ctrl || hit_sel_lo || hit_sel_hi || hit_cnt);

endmodule

// ===== rtl/epc_counters.sv =====
// Counter bank: one wrapping event counter per selector, with clear and read port.
module epc_counters #(
  parameter int NUM_COUNTERS = epc_pkg::NUM_COUNTERS_DEF,
  parameter int COUNT_WIDTH  = epc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          count_en,
  input  logic                          clear,
  input  epc_pkg::sel_vec_t             sel,
  input  logic [epc_pkg::DATA_W-1:0]    event_bits,
  input  logic [epc_pkg::CNT_IDX_W-1:0] rd_idx,
  output logic [2*epc_pkg::DATA_W-1:0]  rd_value
);

  logic [COUNT_WIDTH-1:0] count [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] hit;

  // Pick each counter's event bit; selector zero never counts
  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      hit[i] = (sel[i] != '0) && event_bits[sel[i]];
    end
  end

  // Clear, or advance the counters whose event fired
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (rst || clear) begin
        count[i] <= '0;
      end else if (count_en && hit[i]) begin
        count[i] <= count[i] + COUNT_WIDTH'(1);
      end
    end
  end

  // Select the addressed counter, zero-extended to two bus words
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (rd_idx == epc_pkg::CNT_IDX_W'(i)) begin
        rd_value = (2*epc_pkg::DATA_W)'(count[i]);
      end
    end
  end

endmodule

// ===== rtl/epc_checker.sv =====
// Port-level checker of the performance counter unit and its bind.
module epc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [epc_pkg::FUNC_W-1:0]   req_func,
  input logic [epc_pkg::REG_W-1:0]    req_reg_index,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [epc_pkg::DATA_W-1:0]   rsp_read_data,
  input logic                         rsp_known_register
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  // Hold a stalled result word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                && $stable(rsp_known_register))
    else $error("stalled result word changed or vanished");

  // Produce a result word in the cycle after every accepted request
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> rsp_valid)
    else $error("accepted request gave no result word");

  // Return zero and unknown for a tick
  a_tick_zero: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_func == epc_pkg::FUNC_TICK |=> rsp_read_data == '0 && !rsp_known_register)
    else $error("tick returned data or known flag");

  // Return zero and unknown for a read of the hole between selectors and counters
  a_hole_zero: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_func == epc_pkg::FUNC_READ && !req_reg_index[4]
      && req_reg_index > epc_pkg::REG_SEL_HI
    |=> rsp_read_data == '0 && !rsp_known_register)
    else $error("undefined register read returned data");

  // Keep the response side empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind event_select_performance_counters_top epc_checker u_epc_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_func           (req.func),
  .req_reg_index      (req.reg_index),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_read_data      (rsp.read_data),
  .rsp_known_register (rsp.known_register)
);
